/* rtl/cartridge_rom_bank_mapper_assert.svh */
// Assertion macros shared by the cartridge ROM bank mapper RTL.
// Include by bare file name inside a module; no other dependencies.
`ifndef CARTRIDGE_ROM_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_ROM_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRBM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crbm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crbm assertion failed");

`endif

/* rtl/crbm_pkg.sv */
// Package for the cartridge ROM bank mapper: codes, address constants and
// the memory request type passed between the decoder and the index reducer.
// No dependencies.
`default_nettype none

package crbm_pkg;

    // Default ROM image size in bytes.
    localparam int ROM_BYTES_DEF = 131072;

    // Raw store index width: an 8-bit bank number on top of a 13-bit offset.
    localparam int IDX_W = 21;
    // Wide enough to hold the largest ROM size shifted by the largest fold step.
    localparam int WIDE_W = 26;
    // Smallest supported ROM size is 2**16 bytes, so a raw index holds at most
    // 2**(IDX_W-16) copies of the ROM and this many fold steps reduce it.
    localparam int FOLD_STEPS = IDX_W - 16;

    // Operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Mapper mode codes.
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_KONAMI = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_KONAMI;

    // Bus address map.
    localparam logic [15:0] WIN_BASE   = 16'h4000;
    localparam logic [15:0] WIN_TOP    = 16'hBFFF;
    localparam logic [15:0] BANK0_ADDR = 16'h5000;
    localparam logic [15:0] BANK1_ADDR = 16'h7000;
    localparam logic [15:0] BANK2_ADDR = 16'h9000;
    localparam logic [15:0] BANK3_ADDR = 16'hB000;
    // The lowest window starts at 0x4000, so window number is addr[15:13] - 2.
    localparam logic [2:0]  WIN_FIRST  = 3'd2;

    typedef logic [IDX_W-1:0] t_idx;

    // One store access on its way to the ROM memory.
    typedef struct packed {
        logic       drive;  // read that drives the bus
        logic       wr;     // load that writes the store
        t_idx       idx;    // store index, reduced modulo ROM size when it arrives
        logic [7:0] data;   // load data
    } t_mem_req;

endpackage

`default_nettype wire

/* rtl/crbm_index_reduce.sv */
// Two-stage pipeline that folds a raw store index modulo the ROM size.
// Depends on crbm_pkg.
`default_nettype none

module crbm_index_reduce #(
    parameter int ROM_BYTES = crbm_pkg::ROM_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  crbm_pkg::t_mem_req i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output crbm_pkg::t_mem_req o_req
);

    localparam logic [crbm_pkg::WIDE_W-1:0] MODULUS = crbm_pkg::WIDE_W'(ROM_BYTES);
    // Steps at or above this shift are done in the first stage.
    localparam int SPLIT = crbm_pkg::FOLD_STEPS - 2;

    // One restoring step: subtract ROM_BYTES << shift when it fits.
    function automatic crbm_pkg::t_idx fold(crbm_pkg::t_idx idx, int shift);
        logic [crbm_pkg::WIDE_W-1:0] wide;
        logic [crbm_pkg::WIDE_W-1:0] lim;
        wide = crbm_pkg::WIDE_W'(idx);
        lim  = MODULUS << shift;
        if (wide >= lim) begin
            wide = wide - lim;
        end
        return wide[crbm_pkg::IDX_W-1:0];
    endfunction

    logic               r_a_v;
    logic               r_b_v;
    crbm_pkg::t_mem_req r_a;
    crbm_pkg::t_mem_req r_b;
    crbm_pkg::t_mem_req n_a;
    crbm_pkg::t_mem_req n_b;
    logic               a_ready;
    logic               b_ready;

    assign b_ready = !r_b_v || i_ready;
    assign a_ready = !r_a_v || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_v;
    assign o_req   = r_b;

    always_comb begin
        n_a = i_req;
        for (int k = crbm_pkg::FOLD_STEPS - 1; k >= SPLIT; k--) begin
            n_a.idx = fold(n_a.idx, k);
        end
    end

    always_comb begin
        n_b = r_a;
        for (int k = SPLIT - 1; k >= 0; k--) begin
            n_b.idx = fold(n_b.idx, k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_v <= i_valid;
            end
            if (b_ready) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= n_a;
        end
        if (b_ready && r_a_v) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

/* rtl/cartridge_rom_bank_mapper.sv */
// Top level of the cartridge ROM bank mapper: input register, access decoder,
// bank registers, ROM memory and result register. Depends on crbm_pkg,
// crbm_index_reduce and cartridge_rom_bank_mapper_assert.svh.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_ready      i_operation, i_slot_selected,
//                                                     i_bus_address, i_bus_data,
//                                                     i_load_address
//   result    out        o_out_valid / i_out_ready    o_drive_bus, o_read_data
//   config    in         i_mapper_mode_we             i_mapper_mode
//
// One word is accepted every clock cycle while the result is not stalled; every
// input word yields exactly one result word. The pipeline is input register,
// two index fold stages and the ROM read register; the single ROM port serves
// one load or one read per cycle, which sets the rate of one word per cycle.
// Reset clears the valid bits, restores bank registers 0..3 and selects Konami
// mode; the ROM contents are not cleared. A stalled result holds the whole
// pipeline, and input ready drops only when every stage is full.
`default_nettype none

module cartridge_rom_bank_mapper #(
    parameter int ROM_BYTES = crbm_pkg::ROM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_mapper_mode_we,
    input  logic [1:0]  i_mapper_mode,
    // Input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_slot_selected,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_bus_data,
    input  logic [16:0] i_load_address,
    // Result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_drive_bus,
    output logic [7:0]  o_read_data
);

    `include "cartridge_rom_bank_mapper_assert.svh"

    localparam int ADDR_W = $clog2(ROM_BYTES);
    // Compare width that holds ROM_BYTES itself, even at the top of its range.
    localparam int CMP_W = crbm_pkg::IDX_W + 1;

    // Mode register and the four Konami bank registers.
    logic [1:0]       r_mode;
    logic [3:0][7:0]  r_bank;
    logic [3:0][7:0]  n_bank;
    logic             n_bank_we;

    // Input register.
    logic        r_in_v;
    logic [1:0]  r_in_op;
    logic        r_in_sel;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_data;
    logic [16:0] r_in_laddr;

    // Decoded access and the fold pipeline.
    crbm_pkg::t_mem_req dec_req;
    crbm_pkg::t_mem_req red_req;
    logic               red_ready;
    logic               red_v;
    logic               in_advance;

    // Result register and ROM.
    logic       r_out_v;
    logic       r_out_drive;
    logic [7:0] r_out_rd;
    logic       out_ready;
    logic       mem_en;
    logic [7:0] r_rom [ROM_BYTES];

    logic       in_window;
    logic [2:0] win_num;

    assign out_ready  = !r_out_v || i_out_ready;
    assign o_in_ready = !r_in_v || red_ready;
    assign in_advance = r_in_v && red_ready;
    assign mem_en     = red_v && out_ready;

    assign o_out_valid = r_out_v;
    assign o_drive_bus = r_out_drive;
    // The ROM read register is only meaningful for words that drive the bus.
    assign o_read_data = r_out_drive ? r_out_rd : 8'h00;

    // Address 0x4000-0xBFFF is the cartridge window in plain and Konami modes.
    assign in_window = (r_in_addr >= crbm_pkg::WIN_BASE) && (r_in_addr <= crbm_pkg::WIN_TOP);
    assign win_num   = r_in_addr[15:13] - crbm_pkg::WIN_FIRST;

    // Decode the word in the input register into a store access. Plain and
    // linear indices stay below 0xC000 and so pass the fold stages untouched when
    // the ROM holds at least 0xC000 bytes; Konami indices may exceed the ROM and wrap there.
    always_comb begin
        dec_req      = '0;
        dec_req.data = r_in_data;
        n_bank       = r_bank;
        n_bank_we    = 1'b0;
        case (r_in_op)
            crbm_pkg::OP_LOAD: begin
                // Loads ignore the slot select and the mode, and never drive.
                if (CMP_W'(r_in_laddr) < CMP_W'(ROM_BYTES)) begin
                    dec_req.wr  = 1'b1;
                    dec_req.idx = crbm_pkg::IDX_W'(r_in_laddr);
                end
            end
            crbm_pkg::OP_READ: begin
                if (r_in_sel) begin
                    case (r_mode)
                        crbm_pkg::MODE_PLAIN: begin
                            if (in_window) begin
                                dec_req.drive = 1'b1;
                                dec_req.idx   = crbm_pkg::IDX_W'(r_in_addr - crbm_pkg::WIN_BASE);
                            end
                        end
                        crbm_pkg::MODE_LINEAR: begin
                            if (r_in_addr <= crbm_pkg::WIN_TOP) begin
                                dec_req.drive = 1'b1;
                                dec_req.idx   = crbm_pkg::IDX_W'(r_in_addr);
                            end
                        end
                        crbm_pkg::MODE_KONAMI: begin
                            if (in_window) begin
                                dec_req.drive = 1'b1;
                                dec_req.idx   = {r_bank[win_num[1:0]], r_in_addr[12:0]};
                            end
                        end
                        default: begin
                            // The unused mode code ignores every bus access.
                        end
                    endcase
                end
            end
            crbm_pkg::OP_WRITE: begin
                // Only Konami mode has writable registers; everything else is
                // silently dropped.
                if (r_in_sel && (r_mode == crbm_pkg::MODE_KONAMI)) begin
                    case (r_in_addr)
                        crbm_pkg::BANK0_ADDR: begin
                            n_bank[0] = r_in_data;
                            n_bank_we = 1'b1;
                        end
                        crbm_pkg::BANK1_ADDR: begin
                            n_bank[1] = r_in_data;
                            n_bank_we = 1'b1;
                        end
                        crbm_pkg::BANK2_ADDR: begin
                            n_bank[2] = r_in_data;
                            n_bank_we = 1'b1;
                        end
                        crbm_pkg::BANK3_ADDR: begin
                            n_bank[3] = r_in_data;
                            n_bank_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // The unused operation code does nothing.
            end
        endcase
    end

    // Control state: valid bits, mode and bank registers. A bank register is
    // updated as its write leaves the input register, so the next word sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_mode  <= crbm_pkg::MODE_RESET;
            r_bank  <= {8'd3, 8'd2, 8'd1, 8'd0};
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (out_ready) begin
                r_out_v <= red_v;
            end
            if (i_mapper_mode_we) begin
                r_mode <= i_mapper_mode;
            end
            if (in_advance && n_bank_we) begin
                r_bank <= n_bank;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op    <= i_operation;
            r_in_sel   <= i_slot_selected;
            r_in_addr  <= i_bus_address;
            r_in_data  <= i_bus_data;
            r_in_laddr <= i_load_address;
        end
    end

    crbm_index_reduce #(
        .ROM_BYTES (ROM_BYTES)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .o_ready (red_ready),
        .i_req   (dec_req),
        .o_valid (red_v),
        .i_ready (out_ready),
        .o_req   (red_req)
    );

    // Single-port ROM: a load writes, a read is captured in the result
    // register. Loads and reads reach this port in arrival order.
    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (red_req.wr) begin
                r_rom[red_req.idx[ADDR_W-1:0]] <= red_req.data;
            end
            r_out_rd <= r_rom[red_req.idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_drive <= 1'b0;
        end else if (mem_en) begin
            r_out_drive <= red_req.drive;
        end
    end

    // Input ready can only drop when the pipeline is full back from a stalled result.
    `CRBM_ASSERT_IMPLIES(a_ready_only_on_stall, i_clk, i_rst_n,
        !o_in_ready, o_out_valid && !i_out_ready)

    // Every folded index lands inside the ROM.
    `CRBM_ASSERT_IMPLIES(a_index_in_range, i_clk, i_rst_n,
        red_v, CMP_W'(red_req.idx) < CMP_W'(ROM_BYTES))

    // Bank registers change only under Konami mode.
    `CRBM_ASSERT_IMPLIES(a_bank_konami_only, i_clk, i_rst_n,
        $past(i_rst_n) && !$stable(r_bank), $past(r_mode) == crbm_pkg::MODE_KONAMI)

    // A driving read that enters the result register is presented next cycle.
    `CRBM_ASSERT_NEXT(a_drive_presented, i_clk, i_rst_n,
        mem_en && red_req.drive, o_out_valid && o_drive_bus)

endmodule

`default_nettype wire
